// ===== rtl/core/tss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tss_pkg
// shared constants and helpers for the triangle scanline span unit
// ----------------------------------------------------------------------------
package tss_pkg;

    // quotient bits resolved in each divider stage
    localparam int DIV_BPS = 3;

    // number of divider stages for a given coordinate width
    function automatic int div_stages(input int cw);
        return (cw + DIV_BPS - 1) / DIV_BPS;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/triangle_scanline_span_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_scanline_span_unit
// scanline span of a filled triangle: sort, edge setup, multiply, divide
// ----------------------------------------------------------------------------
// one input beat carries three vertices and a row; one output beat carries
// the span of that row: left and right x (floor of the interpolated long
// edge and active short edge), the row echoed, and a flag in m_tuser that
// is set when the row lies within the triangle's y range. rows outside give
// x_left = x_right = 0; a flat triangle gives min and max of the three x.
// pipeline: sort, setup, multiply, ceil(COORD_BITS/3) divider stages and an
// output register. one beat per cycle is taken and delivered while m_tready
// is high; the rate is set by the per-stage handshake, no unit is shared
// between beats.
// when m_tready is low the stages fill up behind the output register, and
// s_tready drops only once every stage holds a beat; nothing is lost or
// repeated. reset clears the stage valid bits only; the block keeps no
// state between beats.
// ----------------------------------------------------------------------------
module triangle_scanline_span_unit #(
    parameter int COORD_BITS = 12,
    localparam int C  = COORD_BITS,
    localparam int IW = ((7 * COORD_BITS + 7) / 8) * 8,
    localparam int OW = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int ND = tss_pkg::div_stages(COORD_BITS)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, row_y, zero pad
    input  wire logic [IW-1:0] s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // row_out, x_left, x_right, zero pad
    output logic      [OW-1:0] m_tdata,
    // span_valid
    output logic               m_tuser
);
    import tss_pkg::*;

    localparam int ST_SORT = 0;
    localparam int ST_SET  = 1;
    localparam int ST_MUL  = 2;
    localparam int ST_DIV  = 3;
    localparam int ST_OUT  = 3 + ND;
    localparam int NST     = 4 + ND;

    typedef struct packed {
        logic         span_ok;
        logic         degen;
        logic [C-1:0] row;
        logic [C-1:0] xmin;
        logic [C-1:0] xmax;
        logic [C-1:0] xs_p;
        logic         neg_p;
        logic [C-1:0] xs_q;
        logic         neg_q;
    } side_t;

    // ---------------- handshake ----------------
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !v_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    v_reg[k] <= (k == 0) ? s_tvalid : v_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NST-1];

    // ---------------- sort ----------------
    logic [C-1:0] xa_next, ya_next, xb_next, yb_next, xc_next, yc_next;
    logic [C-1:0] xa_reg, ya_reg, xb_reg, yb_reg, xc_reg, yc_reg, row0_reg;

    always_comb begin
        logic [C-1:0] tx;
        logic [C-1:0] ty;
        tx = '0;
        ty = '0;
        xa_next = s_tdata[0*C +: C];
        ya_next = s_tdata[1*C +: C];
        xb_next = s_tdata[2*C +: C];
        yb_next = s_tdata[3*C +: C];
        xc_next = s_tdata[4*C +: C];
        yc_next = s_tdata[5*C +: C];
        if (yb_next < ya_next) begin
            tx = xa_next; ty = ya_next;
            xa_next = xb_next; ya_next = yb_next;
            xb_next = tx; yb_next = ty;
        end
        if (yc_next < ya_next) begin
            tx = xa_next; ty = ya_next;
            xa_next = xc_next; ya_next = yc_next;
            xc_next = tx; yc_next = ty;
        end
        if (yc_next < yb_next) begin
            tx = xb_next; ty = yb_next;
            xb_next = xc_next; yb_next = yc_next;
            xc_next = tx; yc_next = ty;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SORT]) begin
            xa_reg   <= xa_next;
            ya_reg   <= ya_next;
            xb_reg   <= xb_next;
            yb_reg   <= yb_next;
            xc_reg   <= xc_next;
            yc_reg   <= yc_next;
            row0_reg <= s_tdata[6*C +: C];
        end
    end

    // ---------------- edge setup ----------------
    side_t        side1_next, side1_reg;
    logic [C-1:0] mag_p_next, t_p_next, den_p_next;
    logic [C-1:0] mag_q_next, t_q_next, den_q_next;
    logic [C-1:0] mag_p_reg, t_p_reg, den_p_reg;
    logic [C-1:0] mag_q_reg, t_q_reg, den_q_reg;

    always_comb begin
        logic         lower;
        logic         live;
        logic [C:0]   dx_p;
        logic [C:0]   dx_q;
        logic [C-1:0] xlo;
        logic [C-1:0] xhi;
        side1_next.row     = row0_reg;
        side1_next.span_ok = (row0_reg >= ya_reg) && (row0_reg <= yc_reg);
        side1_next.degen   = (yc_reg == ya_reg);
        lower = (row0_reg > yb_reg) || (yb_reg == ya_reg);
        live  = side1_next.span_ok && !side1_next.degen;

        xlo = xa_reg;
        xhi = xa_reg;
        if (xb_reg < xlo) xlo = xb_reg;
        if (xb_reg > xhi) xhi = xb_reg;
        if (xc_reg < xlo) xlo = xc_reg;
        if (xc_reg > xhi) xhi = xc_reg;
        side1_next.xmin = xlo;
        side1_next.xmax = xhi;

        dx_p            = {1'b0, xc_reg} - {1'b0, xa_reg};
        side1_next.xs_p = xa_reg;
        t_p_next        = live ? row0_reg - ya_reg : '0;
        den_p_next      = live ? yc_reg - ya_reg : {{(C-1){1'b0}}, 1'b1};

        if (lower) begin
            dx_q            = {1'b0, xc_reg} - {1'b0, xb_reg};
            side1_next.xs_q = xb_reg;
            t_q_next        = live ? row0_reg - yb_reg : '0;
            den_q_next      = live ? yc_reg - yb_reg : {{(C-1){1'b0}}, 1'b1};
        end else begin
            dx_q            = {1'b0, xb_reg} - {1'b0, xa_reg};
            side1_next.xs_q = xa_reg;
            t_q_next        = live ? row0_reg - ya_reg : '0;
            den_q_next      = live ? yb_reg - ya_reg : {{(C-1){1'b0}}, 1'b1};
        end

        side1_next.neg_p = dx_p[C];
        side1_next.neg_q = dx_q[C];
        mag_p_next = dx_p[C] ? C'(-dx_p) : dx_p[C-1:0];
        mag_q_next = dx_q[C] ? C'(-dx_q) : dx_q[C-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SET]) begin
            side1_reg <= side1_next;
            mag_p_reg <= mag_p_next;
            t_p_reg   <= t_p_next;
            den_p_reg <= den_p_next;
            mag_q_reg <= mag_q_next;
            t_q_reg   <= t_q_next;
            den_q_reg <= den_q_next;
        end
    end

    // ---------------- multiply ----------------
    side_t          side2_reg;
    logic [2*C-1:0] prod_p_reg, prod_q_reg;
    logic [C-1:0]   den2_p_reg, den2_q_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_MUL]) begin
            side2_reg  <= side1_reg;
            prod_p_reg <= (2*C)'(mag_p_reg) * (2*C)'(t_p_reg);
            prod_q_reg <= (2*C)'(mag_q_reg) * (2*C)'(t_q_reg);
            den2_p_reg <= den_p_reg;
            den2_q_reg <= den_q_reg;
        end
    end

    // ---------------- divide ----------------
    side_t        sided_reg [ND];
    logic [C-1:0] quo_p, quo_q;
    logic         nz_p, nz_q;

    tss_div #(.CW(C)) u_div_p (
        .aclk   (aclk),
        .en     (en[ST_DIV +: ND]),
        .num    (prod_p_reg),
        .den    (den2_p_reg),
        .quo    (quo_p),
        .rem_nz (nz_p)
    );

    tss_div #(.CW(C)) u_div_q (
        .aclk   (aclk),
        .en     (en[ST_DIV +: ND]),
        .num    (prod_q_reg),
        .den    (den2_q_reg),
        .quo    (quo_q),
        .rem_nz (nz_q)
    );

    always_ff @(posedge aclk) begin
        for (int s = 0; s < ND; s++) begin
            if (en[ST_DIV + s]) begin
                sided_reg[s] <= (s == 0) ? side2_reg : sided_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // ---------------- floor, order, output ----------------
    side_t        sidef;
    logic [C-1:0] xp_next, xq_next, xl_next, xr_next;
    logic [C-1:0] row_out_reg, x_left_reg, x_right_reg;
    logic         span_valid_reg;

    assign sidef = sided_reg[ND-1];

    always_comb begin
        xp_next = sidef.neg_p ? sidef.xs_p - quo_p - C'(nz_p) : sidef.xs_p + quo_p;
        xq_next = sidef.neg_q ? sidef.xs_q - quo_q - C'(nz_q) : sidef.xs_q + quo_q;
        priority if (!sidef.span_ok) begin
            xl_next = '0;
            xr_next = '0;
        end else if (sidef.degen) begin
            xl_next = sidef.xmin;
            xr_next = sidef.xmax;
        end else if (xp_next <= xq_next) begin
            xl_next = xp_next;
            xr_next = xq_next;
        end else begin
            xl_next = xq_next;
            xr_next = xp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            span_valid_reg <= sidef.span_ok;
            row_out_reg    <= sidef.row;
            x_left_reg     <= xl_next;
            x_right_reg    <= xr_next;
        end
    end

    assign m_tuser = span_valid_reg;
    assign m_tdata = OW'({x_right_reg, x_left_reg, row_out_reg});

endmodule
`default_nettype wire

// ===== rtl/core/tss_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tss_div
// pipelined unsigned restoring divider, DIV_BPS quotient bits per stage;
// the quotient must fit CW bits (num >> CW is below den)
// ----------------------------------------------------------------------------
module tss_div #(
    parameter int CW = 12,
    localparam int NS = tss_pkg::div_stages(CW)
) (
    input  wire logic            aclk,
    input  wire logic [NS-1:0]   en,
    input  wire logic [2*CW-1:0] num,
    input  wire logic [CW-1:0]   den,
    output logic      [CW-1:0]   quo,
    output logic                 rem_nz
);
    import tss_pkg::*;

    logic [CW-1:0] rem_reg  [NS];
    logic [CW-1:0] low_reg  [NS];
    logic [CW-1:0] den_reg  [NS];
    logic [CW-1:0] rem_next [NS];
    logic [CW-1:0] low_next [NS];

    always_comb begin
        logic [CW-1:0] rem_w;
        logic [CW-1:0] low_w;
        logic [CW-1:0] den_w;
        logic [CW:0]   trial_w;
        logic          ge_w;
        trial_w = '0;
        ge_w    = 1'b0;
        for (int s = 0; s < NS; s++) begin
            if (s == 0) begin
                rem_w = num[2*CW-1:CW];
                low_w = num[CW-1:0];
                den_w = den;
            end else begin
                rem_w = rem_reg[s-1];
                low_w = low_reg[s-1];
                den_w = den_reg[s-1];
            end
            for (int j = 0; j < DIV_BPS; j++) begin
                if (s * DIV_BPS + j < CW) begin
                    trial_w = {rem_w, low_w[CW-1]};
                    ge_w    = (trial_w >= {1'b0, den_w});
                    low_w   = {low_w[CW-2:0], ge_w};
                    rem_w   = ge_w ? trial_w[CW-1:0] - den_w : trial_w[CW-1:0];
                end
            end
            rem_next[s] = rem_w;
            low_next[s] = low_w;
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
                rem_reg[s] <= rem_next[s];
                low_reg[s] <= low_next[s];
                den_reg[s] <= (s == 0) ? den : den_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign quo    = low_reg[NS-1];
    assign rem_nz = |rem_reg[NS-1];

endmodule
`default_nettype wire

// ===== tb/triangle_scanline_span_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_scanline_span_unit_tb
// self-checking bench for the triangle scanline span unit
// ----------------------------------------------------------------------------
// each accepted triangle/row beat is run through a span predictor (stable y
// sort, long and short edge interpolation with floor division, flat triangle
// and out-of-range rows) and queued; every output beat is compared field by
// field with the oldest queued span. a directed set of corner triangles runs
// first, then random triangles, mostly with the row inside the y range, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module triangle_scanline_span_unit_tb;

    localparam int CW           = 12;
    localparam int IW           = ((7 * CW + 7) / 8) * 8;
    localparam int OW           = ((3 * CW + 7) / 8) * 8;
    localparam int LATENCY      = 4 + (CW + 2) / 3;
    localparam int RANDOM_BEATS = 950;
    localparam int QUIET_BEATS  = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int COORD_MAX    = (1 << CW) - 1;

    typedef struct packed {
        logic [CW-1:0] v0x, v0y, v1x, v1y, v2x, v2y, row;
    } tri_beat_t;

    typedef struct packed {
        logic          span_ok;
        logic [CW-1:0] row;
        logic [CW-1:0] x_left;
        logic [CW-1:0] x_right;
    } span_t;

    class span_scoreboard;
        span_t expected_spans[$];
        int    mismatches;

        function longint floor_div(longint num, longint den);
            longint q;
            q = num / den;
            if ((num % den) != 0 && num < 0) q = q - 1;
            return q;
        endfunction

        function longint edge_at(longint xs, longint ys, longint xe, longint ye,
                                 longint r);
            return xs + floor_div((xe - xs) * (r - ys), ye - ys);
        endfunction

        function span_t predict_span(tri_beat_t t);
            longint xa, ya, xb, yb, xc, yc, r, tx, ty, p, q, lo, hi;
            bit     lower;
            span_t  s;
            xa = t.v0x; ya = t.v0y;
            xb = t.v1x; yb = t.v1y;
            xc = t.v2x; yc = t.v2y;
            r  = t.row;
            lo = 0;
            hi = 0;
            // stable three-compare sort by y
            if (yb < ya) begin
                tx = xa; ty = ya; xa = xb; ya = yb; xb = tx; yb = ty;
            end
            if (yc < ya) begin
                tx = xa; ty = ya; xa = xc; ya = yc; xc = tx; yc = ty;
            end
            if (yc < yb) begin
                tx = xb; ty = yb; xb = xc; yb = yc; xc = tx; yc = ty;
            end
            s.span_ok = (r >= ya) && (r <= yc);
            if (s.span_ok) begin
                if (yc == ya) begin
                    lo = xa; hi = xa;
                    if (xb < lo) lo = xb;
                    if (xb > hi) hi = xb;
                    if (xc < lo) lo = xc;
                    if (xc > hi) hi = xc;
                end else begin
                    lower = (r > yb) || (yb == ya);
                    p = edge_at(xa, ya, xc, yc, r);
                    q = lower ? edge_at(xb, yb, xc, yc, r) : edge_at(xa, ya, xb, yb, r);
                    if (p <= q) begin
                        lo = p; hi = q;
                    end else begin
                        lo = q; hi = p;
                    end
                end
            end
            s.row     = t.row;
            s.x_left  = lo[CW-1:0];
            s.x_right = hi[CW-1:0];
            return s;
        endfunction

        function void note_triangle(tri_beat_t t);
            expected_spans.insert(expected_spans.size(), predict_span(t));
        endfunction

        function void check_span(span_t got);
            span_t want;
            if (expected_spans.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("span beat with nothing expected: ok=%0d row=%0d l=%0d r=%0d",
                             got.span_ok, got.row, got.x_left, got.x_right);
                return;
            end
            want = expected_spans.pop_front();
            if (got.span_ok !== want.span_ok || got.row !== want.row ||
                got.x_left !== want.x_left || got.x_right !== want.x_right) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("span mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             want.span_ok, want.row, want.x_left, want.x_right,
                             got.span_ok, got.row, got.x_left, got.x_right);
            end
        endfunction
    endclass

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [IW-1:0] s_tdata  = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [OW-1:0] m_tdata;
    logic          m_tuser;

    span_scoreboard sb = new;
    bit             idle_on = 1'b1;
    int             stall_left = 0;
    int             cycle_count = 0;

    triangle_scanline_span_unit #(
        .COORD_BITS(CW)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // output side stalls
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 5) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_span({m_tuser, m_tdata[CW-1:0], m_tdata[2*CW-1:CW],
                           m_tdata[3*CW-1:2*CW]});
    end

    task automatic send_triangle(input tri_beat_t t);
        @(negedge aclk);
        s_tdata  = {{(IW - 7 * CW){1'b0}}, t.row, t.v2y, t.v2x, t.v1y, t.v1x, t.v0y, t.v0x};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_triangle(t);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge aclk);
        end
    endtask

    task automatic send_tri(input int x0, y0, x1, y1, x2, y2, r);
        tri_beat_t t;
        t = {x0[CW-1:0], y0[CW-1:0], x1[CW-1:0], y1[CW-1:0], x2[CW-1:0], y2[CW-1:0],
             r[CW-1:0]};
        send_triangle(t);
    endtask

    task automatic drain_spans();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.expected_spans.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [CW-1:0] jitter(input logic [CW-1:0] c);
        int v;
        v = int'(c) + $urandom_range(0, 64) - 32;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return v[CW-1:0];
    endfunction

    function automatic tri_beat_t make_triangle();
        tri_beat_t     t;
        int            kind;
        logic [CW-1:0] ymin, ymax;
        logic [95:0]   rnd;
        kind = $urandom_range(0, 99);
        rnd  = {$urandom, $urandom, $urandom};
        t    = rnd[7*CW-1:0];
        // small triangles around a random point
        if ($urandom_range(0, 3) == 0) begin
            t.v1x = jitter(t.v0x); t.v1y = jitter(t.v0y);
            t.v2x = jitter(t.v0x); t.v2y = jitter(t.v0y);
        end
        if (kind >= 70 && kind < 80) begin
            t.v1y = t.v0y;
            t.v2y = t.v0y;
        end
        ymin = t.v0y; ymax = t.v0y;
        if (t.v1y < ymin) ymin = t.v1y;
        if (t.v2y < ymin) ymin = t.v2y;
        if (t.v1y > ymax) ymax = t.v1y;
        if (t.v2y > ymax) ymax = t.v2y;
        if (kind < 70)
            t.row = CW'($urandom_range(ymax, ymin));
        else if (kind < 80)
            t.row = ($urandom_range(0, 1) == 0) ? t.v0y : jitter(t.v0y);
        else if (kind < 90)
            case ($urandom_range(0, 2))
                0:       t.row = t.v0y;
                1:       t.row = t.v1y;
                default: t.row = t.v2y;
            endcase
        return t;
    endfunction

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // extremes and flat triangles
        send_tri(0, 0, 0, 0, 0, 0, 0);
        send_tri(4095, 4095, 4095, 4095, 4095, 4095, 4095);
        send_tri(10, 100, 4000, 100, 2000, 100, 100);
        send_tri(10, 100, 4000, 100, 2000, 100, 101);
        send_tri(4095, 0, 0, 0, 17, 0, 0);
        // rows outside the y range
        send_tri(100, 50, 4095, 4000, 0, 2000, 10);
        send_tri(100, 50, 4095, 4000, 0, 2000, 4095);
        // upper and lower halves, row on the middle vertex
        send_tri(0, 0, 4095, 2048, 0, 4095, 2048);
        send_tri(0, 0, 4095, 2048, 0, 4095, 2049);
        send_tri(0, 0, 4095, 2048, 0, 4095, 1);
        // flat top and flat bottom
        send_tri(0, 10, 4095, 10, 2000, 4000, 10);
        send_tri(0, 10, 4095, 10, 2000, 4000, 2000);
        send_tri(2000, 10, 0, 4000, 4095, 4000, 4000);
        send_tri(2000, 10, 0, 4000, 4095, 4000, 500);
        // falling edges, floor of negative quotients
        send_tri(4095, 0, 0, 4095, 4095, 4095, 1);
        send_tri(4095, 0, 0, 4095, 4095, 4095, 4094);
        // ties in the sort and descending input order
        send_tri(5, 300, 9, 300, 7, 100, 300);
        send_tri(5, 300, 9, 300, 7, 100, 200);
        send_tri(100, 4000, 200, 2000, 300, 0, 1000);
        send_tri(100, 4000, 200, 2000, 300, 0, 3000);
        send_tri(4095, 0, 0, 1, 4095, 4095, 0);
        send_tri(4095, 0, 0, 1, 4095, 4095, 4095);
        // vertical line
        send_tri(1234, 7, 1234, 3000, 1234, 4095, 2222);
        drain_spans();

        for (int k = 0; k < RANDOM_BEATS; k++) begin
            idle_on = (k < RANDOM_BEATS - QUIET_BEATS) && ((k / 120) % 4 != 3);
            if (k == RANDOM_BEATS / 2) drain_spans();
            send_triangle(make_triangle());
        end
        drain_spans();
        repeat (3 * LATENCY) @(posedge aclk);

        if (sb.mismatches == 0 && sb.expected_spans.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tss_pkg.sv
rtl/core/tss_div.sv
rtl/core/triangle_scanline_span_unit.sv
tb/triangle_scanline_span_unit_tb.sv
